// ===== hw/rtl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes for the peer liveness table.
// ----------------------------------------------------------------------------
package plt_pkg;

	localparam logic [2:0] FN_INSERT  = 3'd0;
	localparam logic [2:0] FN_LOOKUP  = 3'd1;
	localparam logic [2:0] FN_TICK    = 3'd2;
	localparam logic [2:0] FN_REFRESH = 3'd3;
	localparam logic [2:0] FN_EVICT   = 3'd4;
	localparam logic [2:0] FN_DELETE  = 3'd5;

	localparam logic [15:0] TIMEOUT_RESET = 16'd3;

	// decoded operation broadcast to every cell
	typedef struct packed {
		logic en;
		logic ins;
		logic look;
		logic tick;
		logic refr;
		logic evict;
		logic del;
	} cmd_t;

endpackage

// ===== hw/rtl/plt_cell.sv =====
// ----------------------------------------------------------------------------
// plt_cell
// One table position: holds an entry, matches it against the request and
// takes its neighbor's entry on insert or removal.
// ----------------------------------------------------------------------------
module plt_cell #(
	parameter int NAME_W = 64,
	parameter int CNT_W  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  plt_pkg::cmd_t     cmd,
	input  logic [31:0]       req_ip,
	input  logic [15:0]       req_port,
	input  logic [NAME_W-1:0] req_name,
	input  logic [15:0]       limit,
	input  logic              prev_valid,
	input  logic [31:0]       prev_ip,
	input  logic [15:0]       prev_port,
	input  logic [NAME_W-1:0] prev_name,
	input  logic [CNT_W-1:0]  prev_live,
	input  logic              next_valid,
	input  logic [31:0]       next_ip,
	input  logic [15:0]       next_port,
	input  logic [NAME_W-1:0] next_name,
	input  logic [CNT_W-1:0]  next_live,
	input  logic              found_new_in,
	output logic              found_new_out,
	input  logic              found_old_in,
	output logic              found_old_out,
	input  logic [NAME_W-1:0] name_acc_in,
	output logic [NAME_W-1:0] name_acc_out,
	output logic              valid,
	output logic [31:0]       ip,
	output logic [15:0]       port,
	output logic [NAME_W-1:0] name,
	output logic [CNT_W-1:0]  live
);
	import plt_pkg::*;

	localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

	logic              valid_q;
	logic [31:0]       ip_q;
	logic [15:0]       port_q;
	logic [NAME_W-1:0] name_q;
	logic [CNT_W-1:0]  live_q;

	logic addr_hit, name_hit, exp_hit, new_hit, sel_new, old_hit, sel_old;
	logic take_prev, take_next;

	assign addr_hit = valid_q && ip_q == req_ip && port_q == req_port;
	assign name_hit = valid_q && name_q == req_name;
	assign exp_hit  = valid_q && CMP_W'(live_q) >= CMP_W'(limit);

	assign new_hit = ((cmd.refr || cmd.del) && name_hit) || (cmd.evict && exp_hit);
	assign sel_new = new_hit && !found_new_in;
	assign found_new_out = found_new_in || new_hit;

	assign old_hit = cmd.look && addr_hit;
	assign sel_old = old_hit && !found_old_in;
	assign found_old_out = found_old_in || old_hit;

	assign name_acc_out = name_acc_in |
		((sel_old || (cmd.evict && sel_new)) ? name_q : '0);

	assign take_prev = cmd.ins;
	assign take_next = (cmd.evict || cmd.del) && found_new_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.en) begin
			if (take_prev) begin
				valid_q <= prev_valid;
			end else if (take_next) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (take_prev) begin
				ip_q   <= prev_ip;
				port_q <= prev_port;
				name_q <= prev_name;
				live_q <= prev_live;
			end else if (take_next) begin
				ip_q   <= next_ip;
				port_q <= next_port;
				name_q <= next_name;
				live_q <= next_live;
			end else if (cmd.tick && valid_q && live_q != {CNT_W{1'b1}}) begin
				live_q <= live_q + CNT_W'(1);
			end else if (cmd.refr && sel_new) begin
				live_q <= '0;
			end
		end
	end

	assign valid = valid_q;
	assign ip    = ip_q;
	assign port  = port_q;
	assign name  = name_q;
	assign live  = live_q;

endmodule

// ===== hw/rtl/peer_liveness_table_core.sv =====
// ----------------------------------------------------------------------------
// peer_liveness_table_core
// Ordered peer table built from a row of cells, newest entry in cell zero.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with func, ip_address, port_number
// and name_key; one result per request leaves on out_valid/out_ready with
// success, name_out and entry_count.
// A request is accepted in ST_IDLE and then executed in ST_EXEC, in which
// every cell compares its entry, the priority chains ripple along the
// row and the cells shift or compact. No new request is accepted until
// the current one has executed, since in_ready is low during ST_EXEC.
// The result sits in an output register; the next request is accepted while
// it waits. If that register is still full at execute time, execution holds
// until the receiver takes the pending result.
// Users write timeout_limit via timeout_limit_we only when the block is idle;
// not enforced. Reset empties the table at once and sets the limit to 3.
// ----------------------------------------------------------------------------
module peer_liveness_table_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int NAME_BYTES  = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        timeout_limit_we,
	input  logic [15:0] timeout_limit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] ip_address,
	input  logic [15:0] port_number,
	input  logic [63:0] name_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        success,
	output logic [63:0] name_out,
	output logic [4:0]  entry_count
);
	import plt_pkg::*;

	localparam int NAME_W = NAME_BYTES * 8;
	localparam int CW     = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [15:0]       limit_q;
	logic [2:0]        func_q;
	logic [31:0]       ip_q;
	logic [15:0]       port_q;
	logic [NAME_W-1:0] name_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;

	logic        out_valid_q;
	logic        success_q;
	logic [63:0] name_out_q;
	logic [4:0]  count_out_q;

	logic   out_free, full, ok;
	cmd_t   cmd;

	logic              c_valid [MAX_ENTRIES];
	logic [31:0]       c_ip    [MAX_ENTRIES];
	logic [15:0]       c_port  [MAX_ENTRIES];
	logic [NAME_W-1:0] c_name  [MAX_ENTRIES];
	logic [COUNT_WIDTH-1:0] c_live [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_vec;

	logic              found_new [MAX_ENTRIES+1];
	logic              found_old [MAX_ENTRIES+1];
	logic [NAME_W-1:0] name_acc  [MAX_ENTRIES+1];

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign full     = (count_q == CW'(MAX_ENTRIES));

	always_comb begin
		cmd = '0;
		cmd.en = (state_q == ST_EXEC) && out_free;
		case (func_q)
			FN_INSERT:  cmd.ins   = !full;
			FN_LOOKUP:  cmd.look  = 1'b1;
			FN_TICK:    cmd.tick  = 1'b1;
			FN_REFRESH: cmd.refr  = 1'b1;
			FN_EVICT:   cmd.evict = 1'b1;
			FN_DELETE:  cmd.del   = 1'b1;
			default:    cmd.en    = cmd.en;
		endcase
	end

	assign found_new[0]           = 1'b0;
	assign found_old[MAX_ENTRIES] = 1'b0;
	assign name_acc[0]            = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic              pv, nv;
		logic [31:0]       pip, nip;
		logic [15:0]       pport, nport;
		logic [NAME_W-1:0] pname, nname;
		logic [COUNT_WIDTH-1:0] plive, nlive;

		if (i == 0) begin : g_head
			assign pv    = 1'b1;
			assign pip   = ip_q;
			assign pport = port_q;
			assign pname = name_q;
			assign plive = '0;
		end else begin : g_mid
			assign pv    = c_valid[i-1];
			assign pip   = c_ip[i-1];
			assign pport = c_port[i-1];
			assign pname = c_name[i-1];
			assign plive = c_live[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign nv    = 1'b0;
			assign nip   = c_ip[i];
			assign nport = c_port[i];
			assign nname = c_name[i];
			assign nlive = c_live[i];
		end else begin : g_body
			assign nv    = c_valid[i+1];
			assign nip   = c_ip[i+1];
			assign nport = c_port[i+1];
			assign nname = c_name[i+1];
			assign nlive = c_live[i+1];
		end

		plt_cell #(
			.NAME_W(NAME_W),
			.CNT_W (COUNT_WIDTH)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.req_ip       (ip_q),
			.req_port     (port_q),
			.req_name     (name_q),
			.limit        (limit_q),
			.prev_valid   (pv),
			.prev_ip      (pip),
			.prev_port    (pport),
			.prev_name    (pname),
			.prev_live    (plive),
			.next_valid   (nv),
			.next_ip      (nip),
			.next_port    (nport),
			.next_name    (nname),
			.next_live    (nlive),
			.found_new_in (found_new[i]),
			.found_new_out(found_new[i+1]),
			.found_old_in (found_old[i+1]),
			.found_old_out(found_old[i]),
			.name_acc_in  (name_acc[i]),
			.name_acc_out (name_acc[i+1]),
			.valid        (c_valid[i]),
			.ip           (c_ip[i]),
			.port         (c_port[i]),
			.name         (c_name[i]),
			.live         (c_live[i])
		);

		assign valid_vec[i] = c_valid[i];
	end

	always_comb begin
		ok        = 1'b0;
		count_nxt = count_q;
		if (cmd.ins) begin
			ok        = 1'b1;
			count_nxt = count_q + CW'(1);
		end else if (cmd.look) begin
			ok = found_old[0];
		end else if (cmd.refr) begin
			ok = found_new[MAX_ENTRIES];
		end else if (cmd.evict || cmd.del) begin
			ok = found_new[MAX_ENTRIES];
			if (found_new[MAX_ENTRIES]) begin
				count_nxt = count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= TIMEOUT_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (timeout_limit_we) begin
				limit_q <= timeout_limit;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						count_q     <= count_nxt;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			ip_q   <= ip_address;
			port_q <= port_number;
			name_q <= name_key[NAME_W-1:0];
		end
		if (cmd.en) begin
			success_q   <= ok;
			name_out_q  <= 64'(name_acc[MAX_ENTRIES]);
			count_out_q <= 5'(count_nxt);
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign name_out    = name_out_q;
	assign entry_count = count_out_q;

	// valid cells are exactly the counted ones
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with entry count");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ins, cmd.look, cmd.tick, cmd.refr, cmd.evict, cmd.del}))
		else $error("more than one operation decoded");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !out_ready) |=> state_q == ST_EXEC)
		else $error("request executed over a pending result");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.en |=> out_valid_q)
		else $error("executed request produced no result");

endmodule

// ===== verif/plt_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plt_tb_pkg
// Mirror of the peer table used to check the core's results. It tracks the
// ordered entries and the timeout limit, works out the reply of each accepted
// request and compares the replies from the core in order.
// ----------------------------------------------------------------------------
package plt_tb_pkg;

	import plt_pkg::*;

	localparam int          TABLE_DEPTH = 16;
	localparam logic [15:0] LIVE_MAX    = 16'hFFFF;
	localparam logic [2:0]  FN_SPARE6   = 3'd6;
	localparam logic [2:0]  FN_SPARE7   = 3'd7;

	typedef struct {
		logic        ok;
		logic [63:0] name;
		logic [4:0]  count;
	} peer_reply_t;

	class liveness_mirror;
		logic [31:0] ip_tab[TABLE_DEPTH];
		logic [15:0] port_tab[TABLE_DEPTH];
		logic [63:0] name_tab[TABLE_DEPTH];
		logic [15:0] live_tab[TABLE_DEPTH];
		int          fill;
		logic [15:0] limit;
		peer_reply_t expected_replies[$];
		int          fault_count;

		function new();
			fill = 0;
			limit = TIMEOUT_RESET;
			fault_count = 0;
		endfunction

		function void set_limit(logic [15:0] value);
			limit = value;
		endfunction

		function void drop_entry(int pos);
			for (int i = pos; i + 1 < fill; i++) begin
				ip_tab[i] = ip_tab[i + 1];
				port_tab[i] = port_tab[i + 1];
				name_tab[i] = name_tab[i + 1];
				live_tab[i] = live_tab[i + 1];
			end
			fill--;
		endfunction

		function void note_request(logic [2:0] fn, logic [31:0] ip, logic [15:0] port,
				logic [63:0] key);
			peer_reply_t r;
			int hit;
			r.ok = 1'b0;
			r.name = '0;
			hit = -1;
			case (fn)
			FN_INSERT: begin
				if (fill < TABLE_DEPTH) begin
					for (int i = fill; i > 0; i--) begin
						ip_tab[i] = ip_tab[i - 1];
						port_tab[i] = port_tab[i - 1];
						name_tab[i] = name_tab[i - 1];
						live_tab[i] = live_tab[i - 1];
					end
					ip_tab[0] = ip;
					port_tab[0] = port;
					name_tab[0] = key;
					live_tab[0] = '0;
					fill++;
					r.ok = 1'b1;
				end
			end
			FN_LOOKUP: begin
				// last match wins: oldest entry
				for (int i = 0; i < fill; i++) begin
					if (ip_tab[i] == ip && port_tab[i] == port) begin
						r.ok = 1'b1;
						r.name = name_tab[i];
					end
				end
			end
			FN_TICK: begin
				for (int i = 0; i < fill; i++) begin
					if (live_tab[i] != LIVE_MAX)
						live_tab[i] = live_tab[i] + 16'd1;
				end
			end
			FN_REFRESH: begin
				for (int i = 0; i < fill && hit < 0; i++) begin
					if (name_tab[i] == key)
						hit = i;
				end
				if (hit >= 0) begin
					live_tab[hit] = '0;
					r.ok = 1'b1;
				end
			end
			FN_EVICT: begin
				for (int i = 0; i < fill && hit < 0; i++) begin
					if (live_tab[i] >= limit)
						hit = i;
				end
				if (hit >= 0) begin
					r.ok = 1'b1;
					r.name = name_tab[hit];
					drop_entry(hit);
				end
			end
			FN_DELETE: begin
				for (int i = 0; i < fill && hit < 0; i++) begin
					if (name_tab[i] == key)
						hit = i;
				end
				if (hit >= 0) begin
					r.ok = 1'b1;
					drop_entry(hit);
				end
			end
			default: begin
			end
			endcase
			r.count = fill[4:0];
			expected_replies.push_back(r);
		endfunction

		function void check_result(logic ok, logic [63:0] name, logic [4:0] count);
			peer_reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: result with no request pending: success %0b name %h count %0d",
					$time, ok, name, count);
				fault_count++;
				return;
			end
			want = expected_replies.pop_front();
			if (ok !== want.ok) begin
				$display("%0t: success expected %0b actual %0b", $time, want.ok, ok);
				fault_count++;
			end
			if (name !== want.name) begin
				$display("%0t: name_out expected %h actual %h", $time, want.name, name);
				fault_count++;
			end
			if (count !== want.count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time, want.count, count);
				fault_count++;
			end
		endfunction
	endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for peer_liveness_table_core. A short directed sequence is
// followed by random phases with different timeout limits and idle patterns;
// every reply is checked in order against the table mirror.
// ----------------------------------------------------------------------------
module tb_top;

	import plt_pkg::*;
	import plt_tb_pkg::*;

	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 6;
	localparam int POOL_SIZE    = 6;
	localparam int NAME_POOL    = 8;
	localparam logic [63:0] NAME_GAPPED = 64'h0000_0042_0000_0041;
	localparam logic [63:0] NAME_SHORT  = 64'h0000_0000_0000_0041;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        timeout_limit_we = 1'b0;
	logic [15:0] timeout_limit = TIMEOUT_RESET;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  func = FN_INSERT;
	logic [31:0] ip_address = '0;
	logic [15:0] port_number = '0;
	logic [63:0] name_key = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        success;
	logic [63:0] name_out;
	logic [4:0]  entry_count;

	liveness_mirror mirror;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off_req = 1'b0;
	logic [31:0] ip_pool[POOL_SIZE];
	logic [15:0] port_pool[POOL_SIZE];
	logic [63:0] name_pool[NAME_POOL];

	peer_liveness_table_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.timeout_limit_we (timeout_limit_we),
		.timeout_limit    (timeout_limit),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.ip_address       (ip_address),
		.port_number      (port_number),
		.name_key         (name_key),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.success          (success),
		.name_out         (name_out),
		.entry_count      (entry_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic send_request(logic [2:0] fn, logic [31:0] ip, logic [15:0] port,
			logic [63:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		ip_address <= ip;
		port_number <= port;
		name_key <= key;
		do
			@(posedge clk);
		while (!in_ready);
		mirror.note_request(fn, ip, port, key);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (mirror.expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] value);
		timeout_limit_we <= 1'b1;
		timeout_limit <= value;
		@(posedge clk);
		timeout_limit_we <= 1'b0;
		mirror.set_limit(value);
	endtask

	task automatic issue_random(int ins_pct, output bit counted);
		logic [2:0]  fn;
		logic [31:0] ip;
		logic [15:0] port;
		logic [63:0] key;
		int          roll;
		int          idx;
		roll = $urandom_range(99);
		if (roll < ins_pct) begin
			fn = FN_INSERT;
		end else begin
			roll = $urandom_range(99);
			if (roll < 20)
				fn = FN_LOOKUP;
			else if (roll < 40)
				fn = FN_TICK;
			else if (roll < 55)
				fn = FN_REFRESH;
			else if (roll < 75)
				fn = FN_EVICT;
			else if (roll < 93)
				fn = FN_DELETE;
			else if (roll < 96)
				fn = FN_SPARE6;
			else
				fn = FN_SPARE7;
		end
		idx = $urandom_range(POOL_SIZE - 1);
		ip = ip_pool[idx];
		port = port_pool[idx];
		if ($urandom_range(99) < 15) begin
			ip = $urandom;
			port = 16'($urandom);
		end
		key = name_pool[$urandom_range(NAME_POOL - 1)];
		if ($urandom_range(99) < 15)
			key = {$urandom, $urandom};
		send_request(fn, ip, port, key);
		counted = (fn != FN_SPARE6 && fn != FN_SPARE7);
	endtask

	task automatic run_phase(logic [15:0] lim, int send_pct, int recv_pct, int ins_pct,
			int n, bit hold);
		int done;
		bit counted;
		done = 0;
		wait_drained();
		write_limit(lim);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (hold)
			hold_off_req = 1'b1;
		while (done < n) begin
			issue_random(ins_pct, counted);
			if (counted)
				done++;
		end
	endtask

	// result side
	initial begin : drain_results
		bit take;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			take = ($urandom_range(99) >= recv_stall_pct);
			out_ready <= take;
			@(posedge clk);
			if (take && out_valid)
				mirror.check_result(success, name_out, entry_count);
		end
	end

	initial begin : stimulus
		mirror = new();
		ip_pool[0] = '0;
		port_pool[0] = '0;
		ip_pool[1] = '1;
		port_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			ip_pool[i] = $urandom;
			port_pool[i] = 16'($urandom);
		end
		name_pool[0] = '0;
		name_pool[1] = '1;
		name_pool[2] = NAME_GAPPED;
		name_pool[3] = NAME_SHORT;
		for (int i = 4; i < NAME_POOL; i++)
			name_pool[i] = {$urandom, $urandom};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset limit
		send_request(FN_LOOKUP, '1, '1, '0);
		send_request(FN_EVICT, '0, '0, '0);
		send_request(FN_REFRESH, '0, '0, '0);
		send_request(FN_INSERT, '1, '1, '1);
		send_request(FN_INSERT, '0, '0, '0);
		send_request(FN_INSERT, '1, '1, NAME_GAPPED);
		send_request(FN_LOOKUP, '1, '1, '0);
		send_request(FN_LOOKUP, 32'h0A00_0001, 16'd80, '0);
		send_request(FN_REFRESH, '0, '0, NAME_SHORT);
		send_request(FN_REFRESH, '0, '0, NAME_GAPPED);
		send_request(FN_TICK, '0, '0, '0);
		send_request(FN_TICK, '0, '0, '0);
		send_request(FN_REFRESH, '0, '0, '1);
		send_request(FN_TICK, '0, '0, '0);
		send_request(FN_EVICT, '0, '0, '0);
		send_request(FN_DELETE, '0, '0, '0);
		send_request(FN_DELETE, '0, '0, NAME_SHORT);
		send_request(FN_SPARE6, '1, '1, '1);
		send_request(FN_SPARE7, '1, '1, '1);
		send_request(FN_EVICT, '0, '0, '0);

		run_phase(16'd0, 0, 0, 30, 90, 1'b0);
		run_phase(16'hFFFF, 51, 0, 45, 90, 1'b0);
		run_phase(16'd1, 0, 51, 30, 90, 1'b0);
		run_phase(16'd3, 13, 13, 30, 90, 1'b0);
		run_phase(16'($urandom_range(9, 2)), 0, 0, 30, 90, 1'b1);
		run_phase(16'd2, 13, 13, 30, 90, 1'b0);

		wait_drained();
		if (mirror.fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
